[rtl/core/jet_pkg.sv]
package jet_pkg;

   // width of the iteration counter
   localparam int CntW = 8;
   // common width for comparing the 8-bit limit register with the counter cap
   localparam int LimW = (CntW > 8) ? CntW : 8;

   localparam int ZW = 32;
   localparam int EscW = 11;
   localparam int CountOutW = 8;

   // queue between front and back
   localparam int QDepth = 2;
   localparam int QPtrW = 1;
   localparam int QCntW = 2;

   // register indexes of the configuration port
   localparam int CsrIdxW = 4;
   localparam logic [CsrIdxW-1:0] CSR_C_REAL   = 4'd0;
   localparam logic [CsrIdxW-1:0] CSR_C_IMAG   = 4'd1;
   localparam logic [CsrIdxW-1:0] CSR_MAX_ITER = 4'd2;
   localparam logic [CsrIdxW-1:0] CSR_ESC_RSQ  = 4'd3;

   // register reset values
   localparam logic signed [ZW-1:0] CReset    = -32'sd781640;
   localparam logic signed [ZW-1:0] CImReset  = 32'sd118500;
   localparam logic [7:0]           MaxReset  = 8'd255;
   localparam logic [EscW-1:0]      EscReset  = 11'd1600;

   typedef struct packed {
      logic signed [ZW-1:0] c_real;
      logic signed [ZW-1:0] c_imag;
      logic [7:0]           max_iterations;
      logic [EscW-1:0]      escape_radius_sq;
   } cfg_type;

   typedef struct packed {
      logic signed [ZW-1:0] z_real;
      logic signed [ZW-1:0] z_imag;
      logic [CntW-1:0]      limit;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_EVAL,
      ST_DONE
   } state_type;

endpackage

[rtl/core/jet_front.sv]
module jet_front (
   input  logic              clock,
   input  logic              reset,
   input  jet_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic signed [31:0] req_z_real,
   input  logic signed [31:0] req_z_imag,
   output logic              q_valid,
   output jet_pkg::item_type q_item,
   input  logic              q_pop
);
   import jet_pkg::*;

   item_type         mem [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic             push;
   item_type         new_item;

   // cap the limit at what the counter can hold
   function automatic logic [CntW-1:0] cap_limit(input logic [7:0] max_it);
      logic [LimW-1:0] ext;
      logic [LimW-1:0] cap;
      ext = LimW'(max_it);
      cap = LimW'((1 << CntW) - 1);
      if (ext > cap) begin
         return CntW'(cap);
      end
      return CntW'(ext);
   endfunction

   assign req_stall = (cnt_ff == QCntW'(QDepth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (cnt_ff != '0);
   assign q_item    = mem[rd_ptr_ff];

   always_comb begin
      new_item.z_real = req_z_real;
      new_item.z_imag = req_z_imag;
      new_item.limit  = cap_limit(cfg.max_iterations);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCntW'(push) - QCntW'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntW'(QDepth))
      else $error("queue count out of range");
   a_cnt_track: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("queue count missed a push");
`endif

endmodule

[rtl/core/jet_core.sv]
module jet_core (
   input  logic              clock,
   input  logic              reset,
   input  jet_pkg::cfg_type  cfg,
   input  logic              q_valid,
   input  jet_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_iteration_count
);
   import jet_pkg::*;

   state_type            state_ff, state_in;
   logic signed [31:0]   x_ff, x_in;
   logic signed [31:0]   y_ff, y_in;
   logic [CntW-1:0]      cnt_ff, cnt_in;
   logic [CntW-1:0]      lim_ff, lim_in;
   logic signed [63:0]   xx_ff, xx_in;
   logic signed [63:0]   yy_ff, yy_in;
   logic signed [63:0]   xy_ff, xy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_count_ff, rsp_count_in;

   logic signed [63:0]   diff;
   logic signed [43:0]   re_sh;
   logic signed [44:0]   im_sh;
   logic signed [31:0]   nx;
   logic signed [31:0]   ny;
   logic [63:0]          sq_sum;
   logic [43:0]          thresh;
   logic                 escaped;
   logic                 done;
   logic                 out_free;

   function automatic logic signed [31:0] sat32(input logic signed [45:0] v);
      if (v[45:31] == '0 || v[45:31] == '1) begin
         return v[31:0];
      end
      return v[45] ? 32'sh8000_0000 : 32'sh7fff_ffff;
   endfunction

   // products of the current point
   assign xx_in = 64'(x_ff) * 64'(x_ff);
   assign yy_in = 64'(y_ff) * 64'(y_ff);
   assign xy_in = 64'(x_ff) * 64'(y_ff);

   // next point, shifts round toward minus infinity
   assign diff  = xx_ff - yy_ff;
   assign re_sh = diff[63:20];
   assign im_sh = xy_ff[63:19];
   assign nx    = sat32(46'(re_sh) + 46'(cfg.c_real));
   assign ny    = sat32(46'(im_sh) + 46'(cfg.c_imag));

   // magnitude test on the current point
   assign sq_sum  = 64'(xx_ff) + 64'(yy_ff);
   assign thresh  = {13'b0, cfg.escape_radius_sq, 20'b0};
   assign escaped = (sq_sum[63:20] > thresh);
   assign done    = (cnt_ff >= lim_ff) || ((cnt_ff != '0) && escaped);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      cnt_in       = cnt_ff;
      lim_in       = lim_ff;
      q_pop        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               x_in     = q_item.z_real;
               y_in     = q_item.z_imag;
               lim_in   = q_item.limit;
               cnt_in   = '0;
               q_pop    = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (done) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = 8'(cnt_ff);
                  state_in     = ST_IDLE;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               x_in     = nx;
               y_in     = ny;
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = 8'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      cnt_ff       <= cnt_in;
      lim_ff       <= lim_in;
      xx_ff        <= xx_in;
      yy_ff        <= yy_in;
      xy_ff        <= xy_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

`ifndef ASSERT_OFF
   a_count_in_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL && done) |-> (cnt_ff <= lim_ff))
      else $error("iteration count beyond limit");
   a_eval_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_EVAL && $stable(cnt_ff)))
      else $error("evaluation did not follow multiply");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && !$past(q_pop)))
      else $error("queue popped while busy");
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (rsp_valid_ff && $past(rsp_valid_ff)))
      else $error("result waiting with free output register");
`endif

endmodule

[rtl/core/julia_escape_time.sv]
// julia escape-time counter: each item is a starting point z (signed q12.20) and
// the block iterates z = z*z + c until |z|^2 exceeds escape_radius_sq (integer)
// or the count reaches max_iterations, then returns the count as one result item.
// the start point's own magnitude is not tested, so at least one iteration runs
// unless max_iterations is 0. the iteration engine takes an item from the queue,
// then makes count + 1 passes through two states, one for the three 32x32
// products and one for the update and escape test (the last pass only finds
// the exit). a two-entry queue in front of
// the engine takes new items while one iterates, and an output register holds a
// finished count while the next item starts. configuration writes (c_real,
// c_imag, max_iterations, escape_radius_sq at indexes 0..3) take effect on the
// next item and should only be made when idle
module julia_escape_time (
   input  logic               clock,
   input  logic               reset,
   // input item
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_z_real,
   input  logic signed [31:0] req_z_imag,
   // result item
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_iteration_count,
   // configuration writes
   input  logic               csr_wr_en,
   input  logic [jet_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]        csr_wr_data
);
   import jet_pkg::*;

   cfg_type  cfg_ff, cfg_in;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // register file, extra bits of the write data are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_C_REAL:   cfg_in.c_real           = csr_wr_data;
            CSR_C_IMAG:   cfg_in.c_imag           = csr_wr_data;
            CSR_MAX_ITER: cfg_in.max_iterations   = csr_wr_data[7:0];
            CSR_ESC_RSQ:  cfg_in.escape_radius_sq = csr_wr_data[EscW-1:0];
            // unknown index does nothing
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.c_real           <= CReset;
         cfg_ff.c_imag           <= CImReset;
         cfg_ff.max_iterations   <= MaxReset;
         cfg_ff.escape_radius_sq <= EscReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept, attach capped limit, queue
   jet_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_z_real (req_z_real),
      .req_z_imag (req_z_imag),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // back: iteration engine and output register
   jet_core u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_valid             (q_valid),
      .q_item              (q_item),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

[bench/julia_escape_time_checker.sv]
module julia_escape_time_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [31:0]          req_z_real,
   input  logic signed [31:0]          req_z_imag,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [7:0]                  rsp_iteration_count,
   input  logic                        csr_wr_en,
   input  logic [jet_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                 csr_wr_data,
   output int                          fail_count,
   output int                          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import jet_pkg::*;

   localparam int CountCap = (1 << CntW) - 1;

   logic signed [ZW-1:0] c_real_r;
   logic signed [ZW-1:0] c_imag_r;
   logic [7:0]           max_iter_r;
   logic [EscW-1:0]      esc_r;

   logic [7:0] expected_counts[$];
   int         fails = 0;

   // clamp to the signed 32-bit range
   function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) return 64'sh0000_0000_7FFF_FFFF;
      if (v < -64'sh0000_0000_8000_0000) return -64'sh0000_0000_8000_0000;
      return v;
   endfunction

   // iterations of z = z*z + c until |z|^2 passes the limit or the count cap
   function automatic logic [7:0] escape_count(input logic signed [31:0] zr,
                                               input logic signed [31:0] zi);
      logic signed [63:0] x, y, xx, yy, xy, cr, ci;
      logic [63:0]        sum, mag, thresh;
      int unsigned        lim, cnt;
      x = zr;
      y = zi;
      cr = c_real_r;
      ci = c_imag_r;
      lim = max_iter_r;
      if (lim > CountCap) lim = CountCap;
      thresh = 64'(esc_r) << 20;
      mag = '0;
      cnt = 0;
      while (mag <= thresh && cnt < lim) begin
         xx = x * x;
         yy = y * y;
         xy = x * y;
         // arithmetic shifts round toward minus infinity
         x = clamp32(((xx - yy) >>> 20) + cr);
         y = clamp32((xy >>> 19) + ci);
         cnt++;
         sum = $unsigned(x * x) + $unsigned(y * y);
         mag = sum >> 20;
         if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      end
      return cnt[7:0];
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         c_real_r = CReset;
         c_imag_r = CImReset;
         max_iter_r = MaxReset;
         esc_r = EscReset;
         expected_counts.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_C_REAL:   c_real_r = csr_wr_data;
               CSR_C_IMAG:   c_imag_r = csr_wr_data;
               CSR_MAX_ITER: max_iter_r = csr_wr_data[7:0];
               CSR_ESC_RSQ:  esc_r = csr_wr_data[EscW-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               $error("iteration_count: unexpected result item, actual %0d",
                      rsp_iteration_count);
               fails++;
            end else begin
               want = expected_counts.pop_front();
               if (want !== rsp_iteration_count) begin
                  $error("iteration_count mismatch: expected %0d, actual %0d",
                         want, rsp_iteration_count);
                  fails++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_counts.push_back(escape_count(req_z_real, req_z_imag));
      end
      fail_count <= fails;
      pending <= expected_counts.size();
   end

endmodule

[bench/julia_escape_time_tb.sv]
module julia_escape_time_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import jet_pkg::*;

   localparam int PhaseItems   = 60;
   localparam int RandomPhases = 15;
   localparam int HoldCycles   = 400;
   // an item can make up to 255 iterations in the engine
   localparam int DrainCycles  = 600;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [31:0]  req_z_real = '0;
   logic signed [31:0]  req_z_imag = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [7:0]          rsp_iteration_count;
   logic                csr_wr_en = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [31:0]         csr_wr_data = '0;

   int fail_count;
   int pending;

   // set by the stimulus, cleared by the receiver once its long hold is over
   bit hold_off_req = 1'b0;
   // sender offers items back to back
   bit steady = 1'b0;
   // no idling on either side
   bit quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   julia_escape_time DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_z_real          (req_z_real),
      .req_z_imag          (req_z_imag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   julia_escape_time_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_z_real          (req_z_real),
      .req_z_imag          (req_z_imag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .fail_count          (fail_count),
      .pending             (pending)
   );

   // one register write per clock; the caller lowers the enable afterwards
   task automatic put_reg(input logic [CsrIdxW-1:0] idx, input logic [31:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   // all four registers, sometimes followed by a write to an unused index
   task automatic program_regs(input logic [31:0] cr, input logic [31:0] ci,
                               input logic [31:0] mx, input logic [31:0] esc);
      put_reg(CSR_C_REAL, cr);
      put_reg(CSR_C_IMAG, ci);
      put_reg(CSR_MAX_ITER, mx);
      put_reg(CSR_ESC_RSQ, esc);
      if ($urandom_range(0, 1) == 1)
         put_reg(CsrIdxW'($urandom_range(4, 15)), $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // offer one item, maybe after an idle burst, and hold it until accepted
   task automatic send_point(input logic [31:0] zr, input logic [31:0] zi);
      if (!quiet && !steady && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_z_real <= zr;
      req_z_imag <= zi;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // starting points: mostly within +-2.0, some tiny, some full range
   function automatic logic [31:0] rand_point();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         6:       return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         7:       return $urandom;
         8:       return int'($urandom_range(0, 255)) - 128;
         default: begin
            case ($urandom_range(0, 3))
               0:       return 32'h0000_0000;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h8000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
      endcase
   endfunction

   // julia constant: mostly within +-1.0 where the sets are interesting
   function automatic logic [31:0] rand_const();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5, 6: return int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         7, 8:    return int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
         default: return $urandom;
      endcase
   endfunction

   // iteration limit, mostly small to keep the run short; sometimes junk in the upper bits
   function automatic logic [31:0] rand_limit();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'd0;
         1:       v = 32'd1;
         2:       v = 32'd255;
         3, 4, 5: v = $urandom_range(2, 16);
         6, 7:    v = $urandom_range(17, 64);
         default: v = $urandom_range(1, 255);
      endcase
      if ($urandom_range(0, 3) == 0) v = v | ($urandom << 8);
      return v;
   endfunction

   // escape limit on |z|^2, the classic 4 among the picks
   function automatic logic [31:0] rand_radius();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'd0;
         1:       v = 32'd1;
         2:       v = 32'd2047;
         3, 4, 5: v = 32'd4;
         default: v = $urandom_range(0, 2047);
      endcase
      if ($urandom_range(0, 3) == 0) v = v | ($urandom << EscW);
      return v;
   endfunction

   // result side: random stall bursts, one long hold on request, none at the end
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            // long hold so the queue and the engine fill and the input stalls
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_off_req = 1'b0;
         end else if (quiet) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      int phase_n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset constant near the boundary: origin, corner extremes, unit point
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7FFF_FFFF);
      send_point(32'h0000_0001, 32'hFFFF_FFFF);
      send_point(32'h0010_0000, 32'h0000_0000);
      settle();

      // zero maximum: no iteration at all
      program_regs(CReset, CImReset, 32'd0, 32'd1600);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h0000_0000);
      settle();

      // zero escape limit with c = 0: origin never moves, the points near 1.0 escape
      program_regs(32'h0, 32'h0, 32'd255, 32'd0);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h0010_0000, 32'h0000_0000);
      send_point(32'h000F_FFFF, 32'h0000_0000);
      settle();

      // extreme constants, widest escape limit, saturation in the update
      program_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'd255, 32'd2047);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      settle();

      // upper bits of the narrow registers ignored: limit 1, radius 1
      program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hABCD_EF01, 32'hFFFF_F801);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h8000_0000, 32'h0000_0000);
      settle();

      // converging orbit runs to the full count
      program_regs(32'h0, 32'h0, 32'd255, 32'd2047);
      send_point(32'h0008_0000, 32'h0000_0000);
      settle();

      // backpressure: receiver holds off while items keep coming
      program_regs(CReset, CImReset, 32'd8, 32'd1600);
      hold_off_req = 1'b1;
      steady = 1'b1;
      repeat (12) send_point(rand_point(), rand_point());
      steady = 1'b0;
      settle();

      // random phases, each with its own register setting
      for (phase_n = 0; phase_n < RandomPhases; phase_n++) begin
         if (phase_n == RandomPhases - 1) quiet = 1'b1;
         program_regs(rand_const(), rand_const(), rand_limit(), rand_radius());
         repeat (PhaseItems) send_point(rand_point(), rand_point());
         settle();
      end

      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // watchdog, well beyond the slowest legal run
   initial begin
      #(30_000_000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
